// File: hw/rtl/gbn_pkg.sv
package gbn_pkg;

  localparam int SEQ_SPACE = 20;
  localparam int IDX_W = $clog2(SEQ_SPACE);
  localparam int CNT_W = $clog2(SEQ_SPACE + 1);
  localparam int DIST_W = IDX_W + 1;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = CFG_IDX_W'(1);

  localparam logic [4:0] WINDOW_SIZE_RESET = 5'd10;
  localparam logic [7:0] TIMEOUT_LIMIT_RESET = 8'd20;

  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_POLL     = 2'd1,
    OP_POLL_ACK = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] ack_byte;
  } in_t;

  typedef struct packed {
    logic        sent;
    logic [4:0]  sent_seq_byte;
    logic [15:0] sent_segment;
    logic        ack_taken;
    logic        timed_out;
    logic [4:0]  base_seq;
  } out_t;

  typedef struct packed {
    logic [4:0] window_size;
    logic [7:0] timeout_limit;
  } cfg_t;

endpackage

// File: hw/rtl/gbn_cfg_regs.sv
module gbn_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data,
  output gbn_pkg::cfg_t                  cfg
);

  gbn_pkg::cfg_t cfg_r;
  gbn_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        gbn_pkg::CFG_WINDOW_SIZE:   cfg_nxt.window_size = cfg_data[4:0];
        gbn_pkg::CFG_TIMEOUT_LIMIT: cfg_nxt.timeout_limit = cfg_data[7:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_size <= gbn_pkg::WINDOW_SIZE_RESET;
      cfg_r.timeout_limit <= gbn_pkg::TIMEOUT_LIMIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: hw/rtl/gbn_window_core.sv
module gbn_window_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  gbn_pkg::in_t  item,
  input  gbn_pkg::cfg_t cfg,
  output gbn_pkg::out_t result
);

  localparam int S = gbn_pkg::SEQ_SPACE;
  localparam int IW = gbn_pkg::IDX_W;
  localparam int CW = gbn_pkg::CNT_W;
  localparam int DW = gbn_pkg::DIST_W;

  function automatic logic [IW-1:0] ring_dist(input logic [IW-1:0] a, input logic [IW-1:0] b);
    logic [DW-1:0] s;
    s = {1'b0, a} + DW'(S) - {1'b0, b};
    if (s >= DW'(S)) begin
      s = s - DW'(S);
    end
    return s[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] a);
    return (a == IW'(S - 1)) ? '0 : a + IW'(1);
  endfunction

  logic [S-1:0]  seq_free_r, seq_free_nxt;
  logic [IW-1:0] next_seq_r, next_seq_nxt;
  logic [IW-1:0] window_base_r, window_base_nxt;
  logic [15:0]   segment_count_r, segment_count_nxt;
  logic [7:0]    idle_polls_r, idle_polls_nxt;

  logic          is_poll;
  logic          do_send;
  logic [S-1:0]  free_sent;
  logic [IW-1:0] next_sent;
  logic [15:0]   seg_sent;
  logic [IW-1:0] dist_sent;
  logic [CW-1:0] in_flight;
  logic [7:0]    ack_idx;
  logic [IW-1:0] ack_dist;
  logic          ack_ok;
  logic          tmo;
  logic [S-1:0]  ack_mask;
  logic [S-1:0]  tmo_mask;
  logic [IW-1:0] offs;

  always_comb begin
    is_poll = (item.operation == gbn_pkg::OP_POLL) || (item.operation == gbn_pkg::OP_POLL_ACK);
    do_send = is_poll && (8'(ring_dist(next_seq_r, window_base_r)) < 8'(cfg.window_size))
              && seq_free_r[next_seq_r];

    free_sent = seq_free_r;
    next_sent = next_seq_r;
    seg_sent = segment_count_r;
    if (do_send) begin
      free_sent[next_seq_r] = 1'b0;
      next_sent = ring_inc(next_seq_r);
      seg_sent = segment_count_r + 16'd1;
    end

    dist_sent = ring_dist(next_sent, window_base_r);
    if ((dist_sent == '0) && !free_sent[window_base_r]) begin
      in_flight = CW'(S);
    end else begin
      in_flight = CW'(dist_sent);
    end

    ack_idx = item.ack_byte - 8'd1;
    ack_dist = ring_dist(ack_idx[IW-1:0], window_base_r);
    ack_ok = (ack_idx < 8'(S)) && (CW'(ack_dist) < in_flight);
    tmo = (idle_polls_r >= cfg.timeout_limit);

    for (int j = 0; j < S; j++) begin
      offs = ring_dist(IW'(j), window_base_r);
      ack_mask[j] = (offs <= ack_dist);
      tmo_mask[j] = (8'(offs) < 8'(cfg.window_size));
    end

    seq_free_nxt = seq_free_r;
    next_seq_nxt = next_seq_r;
    window_base_nxt = window_base_r;
    segment_count_nxt = segment_count_r;
    idle_polls_nxt = idle_polls_r;
    result = '0;
    result.base_seq = 5'(window_base_r);

    case (item.operation) inside
      gbn_pkg::OP_START: begin
        next_seq_nxt = '0;
        window_base_nxt = '0;
        segment_count_nxt = '0;
        idle_polls_nxt = '0;
        result.base_seq = '0;
      end
      gbn_pkg::OP_POLL, gbn_pkg::OP_POLL_ACK: begin
        result.sent = do_send;
        result.sent_seq_byte = do_send ? 5'(next_seq_r) + 5'd1 : '0;
        result.sent_segment = do_send ? segment_count_r : '0;
        seq_free_nxt = free_sent;
        next_seq_nxt = next_sent;
        segment_count_nxt = seg_sent;
        if (item.operation == gbn_pkg::OP_POLL_ACK) begin
          idle_polls_nxt = '0;
          if (ack_ok) begin
            seq_free_nxt = free_sent | ack_mask;
            window_base_nxt = ring_inc(ack_idx[IW-1:0]);
            result.ack_taken = 1'b1;
          end
        end else if (tmo) begin
          seq_free_nxt = free_sent | tmo_mask;
          segment_count_nxt = seg_sent - 16'(in_flight);
          next_seq_nxt = window_base_r;
          idle_polls_nxt = '0;
          result.timed_out = 1'b1;
        end else begin
          idle_polls_nxt = idle_polls_r + 8'd1;
        end
        result.base_seq = 5'(window_base_nxt);
      end
      default: begin
        result.base_seq = 5'(window_base_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_free_r <= '1;
      next_seq_r <= '0;
      window_base_r <= '0;
      segment_count_r <= '0;
      idle_polls_r <= '0;
    end else if (step) begin
      seq_free_r <= seq_free_nxt;
      next_seq_r <= next_seq_nxt;
      window_base_r <= window_base_nxt;
      segment_count_r <= segment_count_nxt;
      idle_polls_r <= idle_polls_nxt;
    end
  end

`ifndef SYNTHESIS
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && (item.operation == gbn_pkg::OP_START) |=>
      (next_seq_r == '0) && (window_base_r == '0) && (segment_count_r == '0))
    else $error("start transaction did not clear the cursors");

  a_timeout_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.timed_out |=>
      (next_seq_r == $past(window_base_r)) && (idle_polls_r == '0))
    else $error("timeout did not rewind the send cursor");

  a_ack_clears_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.ack_taken |=> (idle_polls_r == '0))
    else $error("accepted ack left the idle count running");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(next_seq_r) && $stable(window_base_r) && $stable(segment_count_r))
    else $error("window state changed without a transaction");
`endif

endmodule

// File: hw/rtl/go_back_n_sender_window_top.sv
// A transaction accepted into the input register passes through the core into the output register on out_.
// Throughput: one transaction per cycle unless out_ready low stalls the output register.
// The input register and the output register let a new transaction enter while a result waits.
// Reset (rst_n low, synchronous) marks all sequence numbers free and clears every cursor.
// Reset also loads window_size with 10 and timeout_limit with 20; no clearing pass is needed.
module go_back_n_sender_window_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  gbn_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output gbn_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data
);

  gbn_pkg::cfg_t cfg;
  gbn_pkg::in_t  in_item_r;
  logic          in_valid_r;
  gbn_pkg::out_t out_item_r;
  logic          out_valid_r;
  gbn_pkg::out_t result;
  logic          advance;

  assign advance = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data = out_item_r;

  gbn_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gbn_window_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

endmodule
